/* rtl/websocket_frame_deframer_defines.svh */
// Assertion macros shared by the deframer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// expr must never hold at a clock edge outside reset
`define WFD_ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("check failed: forbidden condition");

// whenever ante holds, cons holds at the next clock edge
`define WFD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle consequence");

`endif

/* rtl/wfd_pkg.sv */
// Types and constants of the WebSocket frame deframer.
// No dependencies; imported by every deframer module.
`default_nettype none

package wfd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASKKEY,
        PH_PAYLOAD,
        PH_HALTED,
        PH_CLOSED
    } phase_t;

    localparam logic [3:0]  OP_CLOSE      = 4'h8;
    localparam logic [6:0]  LEN_SHORT_MAX = 7'd125;
    localparam logic [6:0]  LEN_CODE_16   = 7'd126;
    localparam logic [2:0]  EXT16_BYTES_M1 = 3'd1;
    localparam logic [2:0]  EXT64_BYTES_M1 = 3'd7;
    localparam logic [2:0]  KEY_BYTES_M1  = 3'd3;

    localparam logic [1:0]  ST_NORMAL = 2'd0;
    localparam logic [1:0]  ST_REJECT = 2'd1;
    localparam logic [1:0]  ST_CLOSED = 2'd2;

    localparam logic [31:0] LENGTH_CAP_RESET = 32'h4000_0000;

    localparam int unsigned Q_DEPTH = 2;

    // request passed from the parser to the output side
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] key;
        logic       has_data;
        logic [3:0] opcode;
        logic       last;
        logic [1:0] status;
    } q_entry_t;

endpackage

`default_nettype wire

/* rtl/wfd_parser.sv */
// Front end: header parser that classifies each received byte.
// Depends on wfd_pkg and websocket_frame_deframer_defines.svh.
`default_nettype none
`include "websocket_frame_deframer_defines.svh"

module wfd_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic [31:0]       length_cap,
    input  logic              q_full,
    output logic              push,
    output wfd_pkg::q_entry_t push_entry
);
    import wfd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_reg, mask_next;
    logic [31:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] remain_reg, remain_next;
    logic [1:0]  pos_reg, pos_next;

    logic        fire;
    logic [6:0]  code;
    logic [31:0] ext_lo;
    logic        ext_ovf;
    logic        len_complete;
    logic [31:0] len_val;
    logic        len_ovf;
    logic        len_reject;
    logic        masked;
    logic        hdr_complete;
    logic [31:0] hdr_len;
    logic        is_close;
    logic        pay_last;
    logic [7:0]  key_byte;
    phase_t      after_header;
    phase_t      after_length;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;
    assign code     = in_byte[6:0];
    assign ext_lo   = {acc_reg[23:0], in_byte};
    assign ext_ovf  = ovf_reg || (acc_reg[31:24] != 8'd0);
    assign is_close = (opcode_reg == OP_CLOSE);
    assign pay_last = (remain_reg == 32'd1);

    always_comb begin
        len_complete = 1'b0;
        len_val      = 32'd0;
        len_ovf      = 1'b0;
        masked       = mask_reg;
        hdr_complete = 1'b0;
        hdr_len      = remain_reg;
        case (phase_reg)
            PH_HDR1: begin
                len_complete = (code <= LEN_SHORT_MAX);
                len_val      = {25'd0, code};
                masked       = in_byte[7];
            end
            PH_EXTLEN: begin
                len_complete = (cnt_reg == 3'd0);
                len_val      = ext_lo;
                len_ovf      = ext_ovf;
            end
            PH_MASKKEY: begin
                hdr_complete = (cnt_reg == 3'd0);
            end
            default: begin
            end
        endcase
        len_reject = len_ovf || (len_val > length_cap);
        if (len_complete && !len_reject && !masked) begin
            hdr_complete = 1'b1;
            hdr_len      = len_val;
        end
        if (hdr_len == 32'd0) begin
            after_header = is_close ? PH_CLOSED : PH_HDR0;
        end else begin
            after_header = PH_PAYLOAD;
        end
        if (len_reject) begin
            after_length = PH_HALTED;
        end else if (masked) begin
            after_length = PH_MASKKEY;
        end else begin
            after_length = after_header;
        end
    end

    always_comb begin
        case (pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        if (fire) begin
            case (phase_reg)
                PH_HDR0: phase_next = PH_HDR1;
                PH_HDR1: begin
                    phase_next = len_complete ? after_length : PH_EXTLEN;
                end
                PH_EXTLEN: begin
                    if (len_complete) phase_next = after_length;
                end
                PH_MASKKEY: begin
                    if (hdr_complete) phase_next = after_header;
                end
                PH_PAYLOAD: begin
                    if (pay_last) phase_next = is_close ? PH_CLOSED : PH_HDR0;
                end
                PH_HALTED: phase_next = PH_HALTED;
                PH_CLOSED: phase_next = PH_CLOSED;
                default:   phase_next = PH_HDR0;
            endcase
        end
    end

    // outputs and datapath
    always_comb begin
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        remain_next = remain_reg;
        pos_next    = pos_reg;
        push        = 1'b0;
        push_entry  = '{raw: 8'd0, key: 8'd0, has_data: 1'b0, opcode: opcode_reg,
                        last: 1'b1, status: ST_NORMAL};
        if (fire) begin
            case (phase_reg)
                PH_HDR0: opcode_next = in_byte[3:0];
                PH_HDR1: begin
                    mask_next = in_byte[7];
                    acc_next  = 32'd0;
                    ovf_next  = 1'b0;
                    cnt_next  = (code == LEN_CODE_16) ? EXT16_BYTES_M1 : EXT64_BYTES_M1;
                end
                PH_EXTLEN: begin
                    acc_next = ext_lo;
                    ovf_next = ext_ovf;
                    if (!len_complete) cnt_next = cnt_reg - 3'd1;
                end
                PH_MASKKEY: begin
                    key_next = {key_reg[23:0], in_byte};
                    if (!hdr_complete) cnt_next = cnt_reg - 3'd1;
                end
                PH_PAYLOAD: begin
                    push                = 1'b1;
                    push_entry.raw      = in_byte;
                    push_entry.key      = mask_reg ? key_byte : 8'd0;
                    push_entry.has_data = 1'b1;
                    push_entry.last     = pay_last;
                    push_entry.status   = (pay_last && is_close) ? ST_CLOSED : ST_NORMAL;
                    pos_next            = pos_reg + 2'd1;
                    remain_next         = remain_reg - 32'd1;
                end
                default: begin
                end
            endcase
            if (len_complete) begin
                if (len_reject) begin
                    push              = 1'b1;
                    push_entry.status = ST_REJECT;
                end else begin
                    remain_next = len_val;
                    if (masked) begin
                        key_next = 32'd0;
                        cnt_next = KEY_BYTES_M1;
                    end
                end
            end
            if (hdr_complete) begin
                pos_next = 2'd0;
                if (hdr_len == 32'd0) begin
                    push              = 1'b1;
                    push_entry.status = is_close ? ST_CLOSED : ST_NORMAL;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= 4'd0;
            mask_reg   <= 1'b0;
            acc_reg    <= 32'd0;
            ovf_reg    <= 1'b0;
            cnt_reg    <= 3'd0;
            key_reg    <= 32'd0;
            remain_reg <= 32'd0;
            pos_reg    <= 2'd0;
        end else begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            acc_reg    <= acc_next;
            ovf_reg    <= ovf_next;
            cnt_reg    <= cnt_next;
            key_reg    <= key_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
        end
    end

    `WFD_ASSERT_NEVER(a_no_req_when_stopped, aclk, aresetn,
        push && (phase_reg == PH_HALTED || phase_reg == PH_CLOSED))
    `WFD_ASSERT_NEXT(a_halt_sticks, aclk, aresetn,
        phase_reg == PH_HALTED, phase_reg == PH_HALTED)
    `WFD_ASSERT_NEVER(a_req_needs_byte, aclk, aresetn, push && !fire)

endmodule

`default_nettype wire

/* rtl/wfd_queue.sv */
// Two-entry request queue between parser and output stage.
// Depends on wfd_pkg and websocket_frame_deframer_defines.svh.
`default_nettype none
`include "websocket_frame_deframer_defines.svh"

module wfd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  wfd_pkg::q_entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output wfd_pkg::q_entry_t pop_entry
);
    import wfd_pkg::*;

    q_entry_t   slot_reg [Q_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'(Q_DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `WFD_ASSERT_NEVER(a_no_overflow, aclk, aresetn, push && full)
    `WFD_ASSERT_NEVER(a_no_underflow, aclk, aresetn, pop && !not_empty)
    `WFD_ASSERT_NEXT(a_count_tracks, aclk, aresetn, push && !pop,
        count_reg == $past(count_reg) + 2'd1)

endmodule

`default_nettype wire

/* rtl/wfd_emitter.sv */
// Back end: unmasks queued requests into the result output register.
// Depends on wfd_pkg.
`default_nettype none

module wfd_emitter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_not_empty,
    input  wfd_pkg::q_entry_t q_entry,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_data_byte,
    output logic              out_has_data,
    output logic [3:0]        out_frame_opcode,
    output logic              out_last_of_frame,
    output logic [1:0]        out_status
);
    import wfd_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic       has_reg;
    logic [3:0] opcode_reg;
    logic       last_reg;
    logic [1:0] status_reg;

    assign pop        = q_not_empty && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg   <= q_entry.has_data ? (q_entry.raw ^ q_entry.key) : 8'd0;
            has_reg    <= q_entry.has_data;
            opcode_reg <= q_entry.opcode;
            last_reg   <= q_entry.last;
            status_reg <= q_entry.status;
        end
    end

    assign out_valid         = valid_reg;
    assign out_data_byte     = data_reg;
    assign out_has_data      = has_reg;
    assign out_frame_opcode  = opcode_reg;
    assign out_last_of_frame = last_reg;
    assign out_status        = status_reg;

endmodule

`default_nettype wire

/* rtl/websocket_frame_deframer.sv */
// WebSocket frame deframer top level: parser, request queue, output stage,
// and the length_cap register on an APB-style port. Depends on wfd_pkg.
//
// Takes one received byte per clock and gives at most one result per byte,
// one per clock sustained. A byte's result is written into the request queue
// at the edge that accepts the byte, then into the output register; s_ready
// drops only while the two-entry request queue is full because m_ready is
// held low. Header, extended length and mask key bytes give no result, but
// an empty frame's last header byte gives one with no data; a too-long
// frame gives one status-1 result and halts the parser until reset; after
// a close frame ends, bytes are still taken but ignored. length_cap (offset 0)
// is to be written by the user only while idle; the block does not enforce it.
`default_nettype none

module websocket_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_data_byte,
    output logic        m_has_data,
    output logic [3:0]  m_frame_opcode,
    output logic        m_last_of_frame,
    output logic [1:0]  m_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wfd_pkg::*;

    logic [31:0] cap_reg, cap_next;
    logic        cap_sel;
    logic        push;
    q_entry_t    push_entry;
    logic        q_full;
    logic        pop;
    logic        q_not_empty;
    q_entry_t    q_entry;

    assign pready  = 1'b1;
    assign cap_sel = (paddr[2] == 1'b0);
    assign prdata  = cap_sel ? cap_reg : 32'd0;

    always_comb begin
        cap_next = cap_reg;
        if (psel && penable && pwrite && cap_sel) cap_next = pwdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= LENGTH_CAP_RESET;
        end else begin
            cap_reg <= cap_next;
        end
    end

    wfd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_byte    (s_rx_byte),
        .length_cap (cap_reg),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    wfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .pop_entry  (q_entry)
    );

    wfd_emitter u_emitter (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_not_empty       (q_not_empty),
        .q_entry           (q_entry),
        .pop               (pop),
        .out_valid         (m_valid),
        .out_ready         (m_ready),
        .out_data_byte     (m_data_byte),
        .out_has_data      (m_has_data),
        .out_frame_opcode  (m_frame_opcode),
        .out_last_of_frame (m_last_of_frame),
        .out_status        (m_status)
    );

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking bench for websocket_frame_deframer: directed and random frame streams,
// a predictor that parses and unmasks each accepted byte, and length_cap over APB.
// Depends on wfd_pkg and the websocket_frame_deframer RTL.
`default_nettype none

module testbench;
    import wfd_pkg::*;

    localparam logic [2:0] LENGTH_CAP_ADDR = 3'd0;
    localparam logic [6:0] LEN_CODE_64     = 7'd127;
    localparam int         TAIL_CYCLES     = 8;
    localparam int         HOLD_CYCLES     = 48;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         IDLE_PCT        = 26;

    typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic [3:0] opcode;
        logic       last;
        logic [1:0] status;
    } deframed_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_valid  = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready  = 1'b0;
    logic [7:0]  m_data_byte;
    logic        m_has_data;
    logic [3:0]  m_frame_opcode;
    logic        m_last_of_frame;
    logic [1:0]  m_status;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    websocket_frame_deframer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_byte    (m_data_byte),
        .m_has_data     (m_has_data),
        .m_frame_opcode (m_frame_opcode),
        .m_last_of_frame(m_last_of_frame),
        .m_status       (m_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 aclk = ~aclk;

    logic [7:0] rx_stream_q[$];
    deframed_t  deframed_q[$];
    int         mismatch_cnt = 0;
    int         src_idle_pct = IDLE_PCT;
    int         snk_idle_pct = IDLE_PCT;
    int         hold_asks    = 0;
    int         hold_seen    = 0;
    int         hold_left    = 0;
    int         stall_cycles = 0;

    // parser mirror
    phase_t      phase     = PH_HDR0;
    logic [3:0]  kind      = 4'h0;
    logic        masked    = 1'b0;
    logic [63:0] len_acc   = 64'h0;
    logic [2:0]  hdr_left  = 3'd0;
    logic [31:0] key_word  = 32'h0;
    logic [31:0] remaining = 32'h0;
    logic [1:0]  key_pos   = 2'd0;
    logic [31:0] cap_copy  = LENGTH_CAP_RESET;

    task automatic queue_byte(input logic [7:0] b);
        rx_stream_q = {rx_stream_q, b};
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("MISMATCH: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
            flag_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
    endtask

    task automatic push_deframed(input logic [7:0] data, input logic has, input logic last,
                                 input logic [1:0] st);
        deframed_t r;
        r.data     = data;
        r.has_data = has;
        r.opcode   = kind;
        r.last     = last;
        r.status   = st;
        deframed_q = {deframed_q, r};
    endtask

    task automatic header_complete();
        key_pos = 2'd0;
        if (remaining == 32'h0) begin
            if (kind == OP_CLOSE) begin
                phase = PH_CLOSED;
                push_deframed(8'h00, 1'b0, 1'b1, ST_CLOSED);
            end else begin
                phase = PH_HDR0;
                push_deframed(8'h00, 1'b0, 1'b1, ST_NORMAL);
            end
        end else begin
            phase = PH_PAYLOAD;
        end
    endtask

    task automatic length_complete();
        if (len_acc > 64'hFFFF_FFFF || len_acc > {32'h0, cap_copy}) begin
            phase = PH_HALTED;
            push_deframed(8'h00, 1'b0, 1'b1, ST_REJECT);
        end else begin
            remaining = len_acc[31:0];
            if (masked) begin
                key_word = 32'h0;
                hdr_left = KEY_BYTES_M1;
                phase    = PH_MASKKEY;
            end else begin
                header_complete();
            end
        end
    endtask

    task automatic track_rx_byte(input logic [7:0] b);
        logic [6:0] code;
        logic [7:0] kb;
        case (phase)
            PH_HDR0: begin
                kind  = b[3:0];
                phase = PH_HDR1;
            end
            PH_HDR1: begin
                masked  = b[7];
                code    = b[6:0];
                len_acc = 64'h0;
                if (code <= LEN_SHORT_MAX) begin
                    len_acc = 64'(code);
                    length_complete();
                end else begin
                    hdr_left = (code == LEN_CODE_16) ? EXT16_BYTES_M1 : EXT64_BYTES_M1;
                    phase    = PH_EXTLEN;
                end
            end
            PH_EXTLEN: begin
                len_acc = {len_acc[55:0], b};
                if (hdr_left == 3'd0)
                    length_complete();
                else
                    hdr_left = hdr_left - 3'd1;
            end
            PH_MASKKEY: begin
                key_word = {key_word[23:0], b};
                if (hdr_left == 3'd0)
                    header_complete();
                else
                    hdr_left = hdr_left - 3'd1;
            end
            PH_PAYLOAD: begin
                // first key byte pairs with payload position 0
                kb        = masked ? 8'(key_word >> (5'd24 - {key_pos, 3'b000})) : 8'h00;
                key_pos   = key_pos + 2'd1;
                remaining = remaining - 32'd1;
                if (remaining == 32'h0) begin
                    if (kind == OP_CLOSE) begin
                        phase = PH_CLOSED;
                        push_deframed(b ^ kb, 1'b1, 1'b1, ST_CLOSED);
                    end else begin
                        phase = PH_HDR0;
                        push_deframed(b ^ kb, 1'b1, 1'b1, ST_NORMAL);
                    end
                end else begin
                    push_deframed(b ^ kb, 1'b1, 1'b0, ST_NORMAL);
                end
            end
            default: ;
        endcase
    endtask

    // sender
    always @(posedge aclk) begin : rx_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                track_rx_byte(s_rx_byte);
            if (!s_valid || s_ready) begin
                if (rx_stream_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= rx_stream_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge aclk) begin : result_monitor
        deframed_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (deframed_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result data %0h has %0d op %0h last %0d st %0d",
                                            m_data_byte, m_has_data, m_frame_opcode,
                                            m_last_of_frame, m_status));
                end else begin
                    want = deframed_q.pop_front();
                    check_field("data_byte", want.data, m_data_byte);
                    check_field("has_data", 8'(want.has_data), 8'(m_has_data));
                    check_field("frame_opcode", 8'(want.opcode), 8'(m_frame_opcode));
                    check_field("last_of_frame", 8'(want.last), 8'(m_last_of_frame));
                    check_field("status", 8'(want.status), 8'(m_status));
                end
            end
            if (hold_seen != hold_asks) begin
                hold_seen <= hold_asks;
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || psel || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic apb_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= LENGTH_CAP_ADDR;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_cap_readback();
        logic [31:0] rd;
        apb_access(1'b0, 32'h0, rd);
        if (rd !== cap_copy)
            flag_mismatch($sformatf("length_cap read expected %0h got %0h", cap_copy, rd));
    endtask

    task automatic set_length_cap(input logic [31:0] v);
        logic [31:0] rd;
        apb_access(1'b1, v, rd);
        cap_copy = v;
        check_cap_readback();
    endtask

    // all bytes taken and all results back, then let header-only bytes settle
    task automatic wait_idle();
        while (rx_stream_q.size() != 0 || s_valid || deframed_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_header(input logic [3:0] flags, input logic [3:0] op, input logic mask_on,
                                input len_form_t form, input logic [63:0] len);
        logic [6:0] code;
        queue_byte({flags, op});
        case (form)
            LEN_EXT16: code = LEN_CODE_16;
            LEN_EXT64: code = LEN_CODE_64;
            default:   code = len[6:0];
        endcase
        queue_byte({mask_on, code});
        if (form == LEN_EXT16) begin
            queue_byte(len[15:8]);
            queue_byte(len[7:0]);
        end
        if (form == LEN_EXT64)
            for (int i = 7; i >= 0; i--)
                queue_byte(len[8*i +: 8]);
    endtask

    task automatic queue_key(input logic [31:0] k);
        for (int i = 3; i >= 0; i--)
            queue_byte(k[8*i +: 8]);
    endtask

    task automatic queue_random_frame(input logic [3:0] op, input logic [31:0] min_len,
                                      input logic [31:0] max_len);
        logic [31:0] lim;
        logic [31:0] len;
        logic        mask_on;
        len_form_t   form;
        int          r;
        r   = $urandom_range(0, 99);
        lim = (r < 70) ? 32'd12 : (r < 95) ? 32'd130 : 32'd300;
        if (lim > max_len) lim = max_len;
        if (lim < min_len) lim = min_len;
        len = $urandom_range(lim, min_len);
        r   = $urandom_range(0, 99);
        if (len <= 32'(LEN_SHORT_MAX) && r < 60)
            form = LEN_SHORT;
        else if (r < 85)
            form = LEN_EXT16;
        else
            form = LEN_EXT64;
        mask_on = 1'($urandom_range(0, 1));
        queue_header(4'($urandom_range(0, 15)), op, mask_on, form, {32'h0, len});
        if (mask_on) queue_key($urandom);
        repeat (len) queue_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [3:0] pick_data_op();
        logic [3:0] op;
        do op = 4'($urandom_range(0, 15)); while (op == OP_CLOSE);
        return op;
    endfunction

    initial begin : stimulus
        logic [31:0] small_cap;
        int          pick;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_cap_readback();

        // directed: byte extremes, masked and unmasked, empty frame, extended length,
        // reserved bits and a reserved opcode
        queue_header(4'h8, 4'h1, 1'b0, LEN_SHORT, 64'd2);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_header(4'h8, 4'h9, 1'b1, LEN_SHORT, 64'd0);
        queue_key($urandom);
        queue_header(4'h8, 4'hA, 1'b1, LEN_SHORT, 64'd3);
        queue_key(32'hFF00_A55A);
        queue_byte(8'hFF);
        queue_byte(8'hFF);
        queue_byte(8'h5A);
        queue_header(4'h7, 4'hF, 1'b0, LEN_EXT16, 64'd1);
        queue_byte(8'h80);
        wait_idle();

        // cap at zero: only empty frames pass
        set_length_cap(32'h0);
        repeat (8) queue_random_frame(pick_data_op(), 32'd0, 32'd0);
        wait_idle();

        set_length_cap(32'hFFFF_FFFF);
        queue_header(4'h8, 4'h2, 1'b1, LEN_SHORT, 64'(LEN_SHORT_MAX));
        queue_key($urandom);
        repeat (LEN_SHORT_MAX) queue_byte(8'($urandom_range(0, 255)));
        while (rx_stream_q.size() < 420)
            queue_random_frame(pick_data_op(), 32'd0, 32'd300);
        while (rx_stream_q.size() > 250)
            @(posedge aclk);
        // no idling, and a long receiver hold so the request queue fills
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_asks++;
        while (rx_stream_q.size() > 120)
            @(posedge aclk);
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;
        wait_idle();

        small_cap = $urandom_range(40, 1);
        set_length_cap(small_cap);
        queue_random_frame(pick_data_op(), small_cap, small_cap);
        while (rx_stream_q.size() < 150)
            queue_random_frame(pick_data_op(), 32'd0, small_cap);
        wait_idle();

        // ending event: close frame, length over cap, or length over 32 bits
        pick = $urandom_range(0, 2);
        case (pick)
            0: begin
                queue_random_frame(OP_CLOSE, 32'd0, (small_cap < 32'd4) ? small_cap : 32'd4);
                repeat (20) queue_byte(8'($urandom_range(0, 255)));
            end
            1: begin
                queue_header(4'($urandom_range(0, 15)), pick_data_op(), 1'($urandom_range(0, 1)),
                             len_form_t'($urandom_range(0, 2)), {32'h0, small_cap + 32'd1});
            end
            default: begin
                set_length_cap(32'hFFFF_FFFF);
                queue_header(4'($urandom_range(0, 15)), pick_data_op(), 1'($urandom_range(0, 1)),
                             LEN_EXT64, {32'($urandom_range(32'hFFFF_FFFF, 1)), 32'($urandom)});
            end
        endcase
        wait_idle();

        if (deframed_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", deframed_q.size()));
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
